### hdl/adf_pkg.sv
// Shared types, constants and hash functions of the adaptive packet filter.
// No dependencies; adf_front, adf_queue, adf_back and the top level import it.
`timescale 1ns / 1ps
package adf_pkg;

   localparam int FLOW_ENTRIES = 4096;
   localparam int SYN_ENTRIES  = 4096;
   localparam int CLEAR_SPAN   = (FLOW_ENTRIES > SYN_ENTRIES) ? FLOW_ENTRIES : SYN_ENTRIES;
   localparam int FLOW_IDX_W   = $clog2(FLOW_ENTRIES);
   localparam int SYN_IDX_W    = $clog2(SYN_ENTRIES);
   localparam int IDX_W        = $clog2(CLEAR_SPAN);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam logic [2:0] REG_FLOW_START  = 3'd0;
   localparam logic [2:0] REG_SYN_START   = 3'd1;
   localparam logic [2:0] REG_WINDOW      = 3'd2;
   localparam logic [2:0] REG_FLOW_FLOOR  = 3'd3;
   localparam logic [2:0] REG_SYN_FLOOR   = 3'd4;

   localparam logic [31:0] RST_FLOW_START = 32'd500;
   localparam logic [31:0] RST_SYN_START  = 32'd100;
   localparam logic [39:0] RST_WINDOW     = 40'd1000000000;
   localparam logic [31:0] RST_FLOW_FLOOR = 32'd50;
   localparam logic [31:0] RST_SYN_FLOOR  = 32'd10;

   localparam logic [15:0] ETHER_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   localparam logic [1:0] CAUSE_NONE      = 2'd0;
   localparam logic [1:0] CAUSE_MALFORMED = 2'd1;
   localparam logic [1:0] CAUSE_SYN       = 2'd2;
   localparam logic [1:0] CAUSE_FLOW      = 2'd3;

   localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;
   // ceil(2^35 / 10): x * RECIP_TEN >> 35 is floor(x / 10) for any 32-bit x
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

   typedef enum logic [1:0] {
      CLS_PASS,
      CLS_MALFORMED,
      CLS_METER
   } cls_type;

   typedef struct packed {
      cls_type     cls;
      logic        syn_chk;
      logic [31:0] addr;
      logic [15:0] port;
      logic [63:0] now;
   } q_entry_type;

   typedef struct packed {
      logic [31:0] flow_start;
      logic [31:0] syn_start;
      logic [39:0] window;
      logic [31:0] flow_floor;
      logic [31:0] syn_floor;
   } cfg_type;

   typedef struct packed {
      logic        used;
      logic [47:0] key;
      logic [63:0] start;
      logic [31:0] cnt;
      logic [31:0] lim;
   } flow_entry_type;

   typedef struct packed {
      logic        used;
      logic [31:0] key;
      logic [63:0] start;
      logic [31:0] cnt;
      logic [31:0] lim;
   } syn_entry_type;

   function automatic logic [FLOW_IDX_W-1:0] flow_hash(input logic [47:0] key);
      logic [FLOW_IDX_W-1:0] h;
      h = '0;
      for (int i = 0; i < 48; i++) h[i % FLOW_IDX_W] = h[i % FLOW_IDX_W] ^ key[i];
      if ({1'b0, h} >= (FLOW_IDX_W+1)'(FLOW_ENTRIES)) h = h - FLOW_IDX_W'(FLOW_ENTRIES);
      return h;
   endfunction

   function automatic logic [SYN_IDX_W-1:0] syn_hash(input logic [31:0] key);
      logic [SYN_IDX_W-1:0] h;
      h = '0;
      for (int i = 0; i < 32; i++) h[i % SYN_IDX_W] = h[i % SYN_IDX_W] ^ key[i];
      if ({1'b0, h} >= (SYN_IDX_W+1)'(SYN_ENTRIES)) h = h - SYN_IDX_W'(SYN_ENTRIES);
      return h;
   endfunction

endpackage

### hdl/adf_req_if.sv
// Packet header channel (valid/ready).
// No dependencies.
`timescale 1ns / 1ps
interface adf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_bytes;
   logic [15:0] ether_kind;
   logic [3:0]  ip_version_field;
   logic [3:0]  ip_header_words;
   logic [7:0]  ip_proto_number;
   logic [31:0] source_address;
   logic [15:0] source_port;
   logic        syn_flag;
   logic        ack_flag;
   logic [3:0]  tcp_header_words;
   logic [15:0] udp_length_field;
   logic [63:0] arrival_time_ns;

   modport source (output valid, frame_bytes, ether_kind, ip_version_field, ip_header_words,
                   ip_proto_number, source_address, source_port, syn_flag, ack_flag,
                   tcp_header_words, udp_length_field, arrival_time_ns, input ready);
   modport sink (input valid, frame_bytes, ether_kind, ip_version_field, ip_header_words,
                 ip_proto_number, source_address, source_port, syn_flag, ack_flag,
                 tcp_header_words, udp_length_field, arrival_time_ns, output ready);
endinterface

### hdl/adf_rsp_if.sv
// Verdict channel (valid/ready).
// No dependencies.
`timescale 1ns / 1ps
interface adf_rsp_if;
   logic       valid;
   logic       ready;
   logic       drop_packet;
   logic [1:0] drop_cause;

   modport source (output valid, drop_packet, drop_cause, input ready);
   modport sink (input valid, drop_packet, drop_cause, output ready);
endinterface

### hdl/adf_ram.sv
// Generic single write, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module adf_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

### hdl/adf_front.sv
// Front end: header checks and classification of each packet beat.
// Depends on adf_pkg and adf_req_if.
`timescale 1ns / 1ps
module adf_front (
   adf_req_if.sink             req,
   input  logic                init_done,
   output logic                push_valid,
   input  logic                push_ready,
   output adf_pkg::q_entry_type push_data
);
   import adf_pkg::*;

   logic [16:0] len;
   logic [6:0]  l4;
   logic [16:0] l4_ext;
   logic        is_tcp;
   logic        tcp_bad;
   logic        udp_bad;
   cls_type     cls;

   assign len    = {1'b0, req.frame_bytes};
   assign l4     = 7'd14 + {1'b0, req.ip_header_words, 2'b00};
   assign l4_ext = {10'b0, l4};
   assign is_tcp = (req.ip_proto_number == PROTO_TCP);

   assign tcp_bad = (l4_ext + 17'd20 > len) || (req.tcp_header_words < 4'd5) ||
                    (l4_ext + {11'b0, req.tcp_header_words, 2'b00} > len);
   assign udp_bad = (l4_ext + 17'd8 > len) || (req.udp_length_field < 16'd8) ||
                    (l4_ext + {1'b0, req.udp_length_field} > len);

   always_comb begin
      priority if (len < 17'd14 || req.ether_kind != ETHER_IPV4) begin
         cls = CLS_PASS;
      end else if (len < 17'd34) begin
         cls = CLS_MALFORMED;
      end else if (req.ip_proto_number != PROTO_TCP && req.ip_proto_number != PROTO_UDP) begin
         cls = CLS_PASS;
      end else if (l4_ext > len) begin
         cls = CLS_PASS;
      end else if (req.ip_header_words < 4'd5 || req.ip_version_field != 4'd4 ||
                   l4_ext == len) begin
         cls = CLS_MALFORMED;
      end else if (is_tcp ? tcp_bad : udp_bad) begin
         cls = CLS_MALFORMED;
      end else if (req.source_port == 16'd0) begin
         cls = CLS_PASS;
      end else begin
         cls = CLS_METER;
      end
   end

   assign req.ready  = push_ready & init_done;
   assign push_valid = req.valid & init_done;

   assign push_data.cls     = cls;
   assign push_data.syn_chk = is_tcp & req.syn_flag & ~req.ack_flag;
   assign push_data.addr    = req.source_address;
   assign push_data.port    = req.source_port;
   assign push_data.now     = req.arrival_time_ns;
endmodule

### hdl/adf_queue.sv
// Short FIFO between the classifier and the metering engine.
// Depends on adf_pkg.
`timescale 1ns / 1ps
module adf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  adf_pkg::q_entry_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output adf_pkg::q_entry_type pop_data
);
   import adf_pkg::*;

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end
endmodule

### hdl/adf_back.sv
// Back end: hashed table probes, window metering, limit adaptation, verdict register.
// Depends on adf_pkg, adf_ram and adf_rsp_if.
`timescale 1ns / 1ps
module adf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  adf_pkg::cfg_type     cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  adf_pkg::q_entry_type pop_data,
   output logic                 init_done,
   adf_rsp_if.source            rsp
);
   import adf_pkg::*;

   typedef enum logic [7:0] {
      ST_INIT  = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_CHECK = 8'b0000_1000,
      ST_TIME  = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_ADAPT = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [IDX_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] probe_ff, probe_in;
   logic        tbl_syn_ff, tbl_syn_in;
   logic [47:0] key_ff, key_in;
   logic [63:0] now_ff, now_in;
   logic [63:0] e_start_ff, e_start_in;
   logic [31:0] e_cnt_ff, e_cnt_in;
   logic [31:0] e_lim_ff, e_lim_in;
   logic [31:0] dv_quo_ff, dv_quo_in;
   logic        drop_ff, drop_in;
   logic [1:0]  cause_ff, cause_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_drop_ff;
   logic [1:0]  rsp_cause_ff;

   flow_entry_type flow_rd, flow_wr;
   syn_entry_type  syn_rd, syn_wr;
   logic           flow_we, syn_we, ram_re;
   logic [IDX_W-1:0] wr_addr;

   logic        w_used;
   logic [63:0] w_start;
   logic [31:0] w_cnt, w_lim;
   logic        we;

   logic        rd_used, rd_match;
   logic [63:0] rd_start;
   logic [31:0] rd_cnt, rd_lim;
   logic [IDX_W-1:0] tbl_last;
   logic [63:0] elapsed;
   logic        expired;
   logic [31:0] cnt_inc;
   logic [32:0] ceil_q, adapt_n;
   logic [31:0] lowest;
   logic        v_pass, v_drop, out_free, emit_load;
   logic [63:0] recip_prod;
   logic [31:0] quo_x10;

   assign init_done = (state_ff != ST_INIT);
   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free  = ~rsp_valid_ff | rsp.ready;
   assign emit_load = (state_ff == ST_EMIT) & out_free;

   assign rd_used  = tbl_syn_ff ? syn_rd.used : flow_rd.used;
   assign rd_match = tbl_syn_ff ? (syn_rd.key == key_ff[47:16]) : (flow_rd.key == key_ff);
   assign rd_start = tbl_syn_ff ? syn_rd.start : flow_rd.start;
   assign rd_cnt   = tbl_syn_ff ? syn_rd.cnt : flow_rd.cnt;
   assign rd_lim   = tbl_syn_ff ? syn_rd.lim : flow_rd.lim;
   assign tbl_last = tbl_syn_ff ? IDX_W'(SYN_ENTRIES-1) : IDX_W'(FLOW_ENTRIES-1);

   assign elapsed = now_ff - e_start_ff;
   assign expired = elapsed > {24'b0, cfg.window};
   assign cnt_inc = (e_cnt_ff == U32_MAX) ? U32_MAX : e_cnt_ff + 32'd1;
   assign lowest  = tbl_syn_ff ? cfg.syn_floor : cfg.flow_floor;

   // floor(lim / 10) by reciprocal multiply, registered in ST_DIV
   assign recip_prod = 64'(e_lim_ff) * 64'(RECIP_TEN);
   assign quo_x10    = {dv_quo_ff[28:0], 3'b000} + {dv_quo_ff[30:0], 1'b0};
   assign ceil_q     = {1'b0, dv_quo_ff} + {32'b0, (e_lim_ff != quo_x10)};

   always_comb begin
      adapt_n = (e_cnt_ff > e_lim_ff) ? ({1'b0, e_lim_ff} - ceil_q)
                                      : ({1'b0, e_lim_ff} + {1'b0, dv_quo_ff});
      if (adapt_n < {1'b0, lowest}) adapt_n = {1'b0, lowest};
      if (adapt_n[32]) adapt_n = {1'b0, U32_MAX};
   end

   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      idx_in     = idx_ff;
      probe_in   = probe_ff;
      tbl_syn_in = tbl_syn_ff;
      key_in     = key_ff;
      now_in     = now_ff;
      e_start_in = e_start_ff;
      e_cnt_in   = e_cnt_ff;
      e_lim_in   = e_lim_ff;
      dv_quo_in  = dv_quo_ff;
      drop_in    = drop_ff;
      cause_in   = cause_ff;
      we         = 1'b0;
      w_used     = 1'b1;
      w_start    = now_ff;
      w_cnt      = 32'd1;
      w_lim      = tbl_syn_ff ? cfg.syn_start : cfg.flow_start;
      wr_addr    = idx_ff;
      ram_re     = 1'b0;
      v_pass     = 1'b0;
      v_drop     = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            w_used     = 1'b0;
            wr_addr    = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == IDX_W'(CLEAR_SPAN-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_data.cls)
                  CLS_PASS: begin
                     drop_in  = 1'b0;
                     cause_in = CAUSE_NONE;
                     state_in = ST_EMIT;
                  end
                  CLS_MALFORMED: begin
                     drop_in  = 1'b1;
                     cause_in = CAUSE_MALFORMED;
                     state_in = ST_EMIT;
                  end
                  CLS_METER: begin
                     key_in     = {pop_data.addr, pop_data.port};
                     now_in     = pop_data.now;
                     tbl_syn_in = pop_data.syn_chk;
                     idx_in     = pop_data.syn_chk ? IDX_W'(syn_hash(pop_data.addr))
                                  : IDX_W'(flow_hash({pop_data.addr, pop_data.port}));
                     probe_in   = '0;
                     state_in   = ST_READ;
                  end
                  default: begin
                     drop_in  = 1'b0;
                     cause_in = CAUSE_NONE;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!rd_used) begin
               we     = 1'b1;
               v_pass = 1'b1;
            end else if (rd_match) begin
               e_start_in = rd_start;
               e_cnt_in   = rd_cnt;
               e_lim_in   = rd_lim;
               state_in   = ST_TIME;
            end else if (probe_ff == tbl_last) begin
               v_pass = 1'b1;
            end else begin
               idx_in   = (idx_ff == tbl_last) ? '0 : idx_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_TIME: begin
            if (expired) begin
               state_in = ST_DIV;
            end else begin
               we      = 1'b1;
               w_start = e_start_ff;
               w_cnt   = cnt_inc;
               w_lim   = e_lim_ff;
               if (cnt_inc > e_lim_ff) v_drop = 1'b1;
               else v_pass = 1'b1;
            end
         end
         ST_DIV: begin
            dv_quo_in = {3'b000, recip_prod[63:35]};
            state_in  = ST_ADAPT;
         end
         ST_ADAPT: begin
            we     = 1'b1;
            w_lim  = adapt_n[31:0];
            v_pass = 1'b1;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase

      if (v_pass) begin
         if (tbl_syn_ff) begin
            tbl_syn_in = 1'b0;
            idx_in     = IDX_W'(flow_hash(key_ff));
            probe_in   = '0;
            state_in   = ST_READ;
         end else begin
            drop_in  = 1'b0;
            cause_in = CAUSE_NONE;
            state_in = ST_EMIT;
         end
      end
      if (v_drop) begin
         drop_in  = 1'b1;
         cause_in = tbl_syn_ff ? CAUSE_SYN : CAUSE_FLOW;
         state_in = ST_EMIT;
      end
   end

   assign flow_we = (state_ff == ST_INIT) ? (int'(clr_ptr_ff) < FLOW_ENTRIES)
                                          : (we & ~tbl_syn_ff);
   assign syn_we  = (state_ff == ST_INIT) ? (int'(clr_ptr_ff) < SYN_ENTRIES)
                                          : (we & tbl_syn_ff);
   assign flow_wr = '{used: w_used, key: key_ff, start: w_start, cnt: w_cnt, lim: w_lim};
   assign syn_wr  = '{used: w_used, key: key_ff[47:16], start: w_start, cnt: w_cnt,
                      lim: w_lim};

   assign rsp_valid_in = emit_load | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      probe_ff   <= probe_in;
      tbl_syn_ff <= tbl_syn_in;
      key_ff     <= key_in;
      now_ff     <= now_in;
      e_start_ff <= e_start_in;
      e_cnt_ff   <= e_cnt_in;
      e_lim_ff   <= e_lim_in;
      dv_quo_ff  <= dv_quo_in;
      drop_ff    <= drop_in;
      cause_ff   <= cause_in;
      if (emit_load) begin
         rsp_drop_ff  <= drop_ff;
         rsp_cause_ff <= cause_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drop_packet = rsp_drop_ff;
   assign rsp.drop_cause  = rsp_cause_ff;

   adf_ram #(.DEPTH(FLOW_ENTRIES), .WIDTH($bits(flow_entry_type))) u_flow_ram (
      .clock   (clock),
      .wr_en   (flow_we),
      .wr_addr (wr_addr[FLOW_IDX_W-1:0]),
      .wr_data (flow_wr),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[FLOW_IDX_W-1:0]),
      .rd_data (flow_rd)
   );

   adf_ram #(.DEPTH(SYN_ENTRIES), .WIDTH($bits(syn_entry_type))) u_syn_ram (
      .clock   (clock),
      .wr_en   (syn_we),
      .wr_addr (wr_addr[SYN_IDX_W-1:0]),
      .wr_data (syn_wr),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[SYN_IDX_W-1:0]),
      .rd_data (syn_rd)
   );
endmodule

### hdl/adaptive_ddos_packet_filter.sv
// Top level of the adaptive packet filter: CSR block, classifier, queue, metering engine.
// Depends on adf_pkg, adf_req_if, adf_rsp_if, adf_front, adf_queue and adf_back.
//
//   port     dir   handshake        beat
//   req_if   in    valid/ready      parsed header fields and timestamp
//   rsp_if   out   valid/ready      drop_packet, drop_cause
//   csr_*    in    APB, pready=1    64-bit register write/read, 8-byte stride
//
// Pass and malformed verdicts go from the queue via ST_IDLE and ST_EMIT to the verdict
// register; metered ones add ST_READ and ST_CHECK per hashed table probe, ST_TIME on a
// found key, ST_DIV and ST_ADAPT on an expired window. The engine handles one beat at a
// time. After reset a clearing pass over CLEAR_SPAN (4096) entries runs before req_if is
// ready. A 4-beat queue lets headers be classified while the engine or rsp_if stalls.
`timescale 1ns / 1ps
module adaptive_ddos_packet_filter (
   input  logic                           clock,
   input  logic                           reset,
   adf_req_if.sink                        req_if,
   adf_rsp_if.source                      rsp_if,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [adf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [adf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [adf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import adf_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic [2:0]  reg_idx;
   logic        csr_wr;
   logic        init_done;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   q_entry_type push_data, pop_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_FLOW_START: cfg_in.flow_start = csr_pwdata[31:0];
            REG_SYN_START:  cfg_in.syn_start  = csr_pwdata[31:0];
            REG_WINDOW:     cfg_in.window     = csr_pwdata[39:0];
            REG_FLOW_FLOOR: cfg_in.flow_floor = csr_pwdata[31:0];
            REG_SYN_FLOOR:  cfg_in.syn_floor  = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FLOW_START: csr_prdata = {32'b0, cfg_ff.flow_start};
         REG_SYN_START:  csr_prdata = {32'b0, cfg_ff.syn_start};
         REG_WINDOW:     csr_prdata = {24'b0, cfg_ff.window};
         REG_FLOW_FLOOR: csr_prdata = {32'b0, cfg_ff.flow_floor};
         REG_SYN_FLOOR:  csr_prdata = {32'b0, cfg_ff.syn_floor};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{flow_start: RST_FLOW_START, syn_start: RST_SYN_START,
                     window: RST_WINDOW, flow_floor: RST_FLOW_FLOOR,
                     syn_floor: RST_SYN_FLOOR};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adf_front u_front (
      .req        (req_if),
      .init_done  (init_done),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   adf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   adf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .init_done (init_done),
      .rsp       (rsp_if)
   );

`ifndef SYNTH
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> init_done)
      else $error("header beat accepted during table clearing");

   a_init_done_sticks: assert property (@(posedge clock) disable iff (reset)
      init_done |=> init_done)
      else $error("clearing pass restarted without reset");

   a_cause_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.drop_packet == (rsp_if.drop_cause != CAUSE_NONE)))
      else $error("drop cause disagrees with verdict");
`endif
endmodule
